[sv/svs_pkg.sv]
// Package for the supply voltage supervisor: widths, constants, register
// codes and the structs passed between its modules. No dependencies.
package svs_pkg;

  // Sizes of the item fields.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned VOLT_W   = 11;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned CAL_W    = 8;
  localparam int unsigned CODE_W   = 5;

  // Behavior constants.
  localparam int unsigned SAMPLES          = 128;
  localparam int unsigned THRESHOLD_OFFSET = 20;
  localparam int unsigned SHUTDOWN_DELAY   = 6000;
  localparam int unsigned CAL_BASE         = 900;
  localparam int unsigned VOLT_DIV         = 2500;
  localparam int unsigned THRESH_SCALE     = 10;
  localparam int unsigned MARGIN_RED       = 50;
  localparam int unsigned MARGIN_ORANGE    = 100;
  localparam int unsigned MARGIN_YELLOW    = 150;

  // Accumulator holds SAMPLES full-scale samples; counter holds SAMPLES itself.
  localparam int unsigned SUM_W = $clog2(SAMPLES * (2 ** SAMPLE_W));
  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);

  // Scale factor (cal + 900) and the average times that factor.
  localparam int unsigned SCALE_W = $clog2((2 ** CAL_W) - 1 + CAL_BASE + 1);
  localparam int unsigned PROD_W  = SAMPLE_W + SCALE_W;

  // Division by 2500 as a multiplication by a rounded-up reciprocal.
  localparam int unsigned      RECIP_SHIFT = 32;
  localparam longint unsigned  RECIP       = ((64'd1 << RECIP_SHIFT) + VOLT_DIV - 1) / VOLT_DIV;
  localparam int unsigned      RECIP_W     = $clog2(RECIP + 1);
  localparam int unsigned      FULL_W      = PROD_W + RECIP_W;

  // Thresholds are compared at this width (threshold up to 510 plus margin).
  localparam int unsigned THR_W = 12;

  // Configuration port.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_CAL      = 2'd0,
    REG_THRESH   = 2'd1,
    REG_SHUTDOWN = 2'd2
  } svs_reg_t;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_NORMAL = 2'd0,
    LVL_YELLOW = 2'd1,
    LVL_ORANGE = 2'd2,
    LVL_RED    = 2'd3
  } svs_level_t;

  typedef struct packed {
    logic [CAL_W-1:0]  cal;
    logic [CODE_W-1:0] code;
    logic              shutdown_enable;
  } svs_cfg_t;

  // Item leaving the scaling pipeline toward the decision stage.
  typedef struct packed {
    logic              valid;
    logic              measure;
    logic              tx;
    logic [TICK_W-1:0] now;
    logic [VOLT_W-1:0] volt;
  } svs_meas_t;

endpackage

[sv/svs_in_if.sv]
// Input channel of the supply voltage supervisor: valid/ready plus one
// converter sample, the transmit flag and the system time. Uses svs_pkg.
interface svs_in_if;
  logic                          valid;
  logic                          ready;
  logic [svs_pkg::SAMPLE_W-1:0]  adc_sample;
  logic                          transmitting;
  logic [svs_pkg::TICK_W-1:0]    now_ticks;

  modport source (output valid, output adc_sample, output transmitting, output now_ticks,
                  input ready);
  modport sink   (input valid, input adc_sample, input transmitting, input now_ticks,
                  output ready);
endinterface

[sv/svs_out_if.sv]
// Result channel of the supply voltage supervisor: valid/ready plus the
// measurement and supervision fields. Uses svs_pkg.
interface svs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         measured;
  logic [svs_pkg::VOLT_W-1:0]   voltage;
  logic                         display_update;
  logic                         undervoltage;
  logic                         power_down_request;
  logic [svs_pkg::LEVEL_W-1:0]  level;

  modport source (output valid, output measured, output voltage, output display_update,
                  output undervoltage, output power_down_request, output level,
                  input ready);
  modport sink   (input valid, input measured, input voltage, input display_update,
                  input undervoltage, input power_down_request, input level,
                  output ready);
endinterface

[sv/svs_cfg_regs.sv]
// APB-style configuration registers of the supply voltage supervisor.
// Depends on svs_pkg for the register codes and the svs_cfg_t struct.
module svs_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [svs_pkg::ADDR_W-1:0]   paddr,
  input  logic [svs_pkg::DATA_W-1:0]   pwdata,
  output logic [svs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output svs_pkg::svs_cfg_t            cfg
);

  svs_pkg::svs_cfg_t cfg_r;
  svs_pkg::svs_reg_t reg_sel;
  logic              wr_en;

  assign reg_sel = svs_pkg::svs_reg_t'(paddr[svs_pkg::ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal             <= svs_pkg::CAL_W'(100);
      cfg_r.code            <= '0;
      cfg_r.shutdown_enable <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        svs_pkg::REG_CAL:      cfg_r.cal             <= pwdata[svs_pkg::CAL_W-1:0];
        svs_pkg::REG_THRESH:   cfg_r.code            <= pwdata[svs_pkg::CODE_W-1:0];
        svs_pkg::REG_SHUTDOWN: cfg_r.shutdown_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      svs_pkg::REG_CAL:      prdata = svs_pkg::DATA_W'(cfg_r.cal);
      svs_pkg::REG_THRESH:   prdata = svs_pkg::DATA_W'(cfg_r.code);
      svs_pkg::REG_SHUTDOWN: prdata = svs_pkg::DATA_W'(cfg_r.shutdown_enable);
      default:               prdata = '0;
    endcase
  end

endmodule

[sv/svs_scale.sv]
// Front of the supervisor pipeline: input register, sample accumulator and
// the two multiply stages that turn the sum into hundredths of a volt.
// Depends on svs_pkg and svs_in_if.
module svs_scale (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  svs_in_if.sink              in_ch,
  input  svs_pkg::svs_cfg_t   cfg,
  output svs_pkg::svs_meas_t  meas
);

  // Input register.
  logic                          s0_valid_r;
  logic [svs_pkg::SAMPLE_W-1:0]  s0_sample_r;
  logic                          s0_tx_r;
  logic [svs_pkg::TICK_W-1:0]    s0_now_r;

  // Accumulator state.
  logic [svs_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [svs_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  // Stage after the first multiply.
  logic                          s1_valid_r;
  logic                          s1_measure_r;
  logic                          s1_tx_r;
  logic [svs_pkg::TICK_W-1:0]    s1_now_r;
  logic [svs_pkg::PROD_W-1:0]    s1_prod_r;

  svs_pkg::svs_meas_t            s2_r;

  logic                          measure_a;
  logic [svs_pkg::SAMPLE_W-1:0]  avg_a;
  logic [svs_pkg::SCALE_W-1:0]   scale_a;
  logic [svs_pkg::PROD_W-1:0]    prod_a;
  logic [svs_pkg::FULL_W-1:0]    full_b;

  // The whole pipeline moves together, so the input is taken whenever it moves.
  assign in_ch.ready = en;
  assign meas        = s2_r;

  assign measure_a = (cnt_r == svs_pkg::CNT_W'(svs_pkg::SAMPLES));
  assign avg_a     = svs_pkg::SAMPLE_W'(sum_r / svs_pkg::SUM_W'(svs_pkg::SAMPLES));
  assign scale_a   = svs_pkg::SCALE_W'(cfg.cal) + svs_pkg::SCALE_W'(svs_pkg::CAL_BASE);
  assign prod_a    = svs_pkg::PROD_W'(avg_a) * svs_pkg::PROD_W'(scale_a);
  assign full_b    = svs_pkg::FULL_W'(s1_prod_r) * svs_pkg::FULL_W'(svs_pkg::RECIP);

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (s0_valid_r) begin
      if (measure_a) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_r + svs_pkg::SUM_W'(s0_sample_r);
        cnt_nxt = cnt_r + svs_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_r.valid <= 1'b0;
      sum_r      <= '0;
      cnt_r      <= '0;
    end else if (en) begin
      s0_valid_r   <= in_ch.valid;
      s1_valid_r   <= s0_valid_r;
      s2_r.valid   <= s1_valid_r;
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      s0_sample_r  <= in_ch.adc_sample;
      s0_tx_r      <= in_ch.transmitting;
      s0_now_r     <= in_ch.now_ticks;
      s1_measure_r <= measure_a;
      s1_tx_r      <= s0_tx_r;
      s1_now_r     <= s0_now_r;
      s1_prod_r    <= prod_a;
      s2_r.measure <= s1_measure_r;
      s2_r.tx      <= s1_tx_r;
      s2_r.now     <= s1_now_r;
      s2_r.volt    <= full_b[svs_pkg::RECIP_SHIFT +: svs_pkg::VOLT_W];
    end
  end

endmodule

[sv/svs_decide.sv]
// Decision stage of the supervisor: undervoltage flag, shutdown deadline,
// margin level and the result register. Depends on svs_pkg and svs_out_if.
module svs_decide (
  input  logic                clk,
  input  logic                rst_n,
  input  svs_pkg::svs_meas_t  meas,
  input  svs_pkg::svs_cfg_t   cfg,
  svs_out_if.source           out_ch,
  output logic                en
);

  logic [svs_pkg::VOLT_W-1:0]   voltage_r, voltage_nxt;
  logic                         uv_flag_r, uv_flag_nxt;
  logic [svs_pkg::TICK_W-1:0]   deadline_r, deadline_nxt;
  logic [svs_pkg::TICK_W-1:0]   deadline_new;
  logic [svs_pkg::THR_W-1:0]    thr;
  logic [svs_pkg::THR_W-1:0]    volt_w;
  logic [svs_pkg::THR_W-1:0]    meas_w;
  logic                         update;
  logic                         pdown;
  logic                         measuring;
  svs_pkg::svs_level_t          level;

  logic                         out_valid_r;
  logic                         out_measured_r;
  logic [svs_pkg::VOLT_W-1:0]   out_voltage_r;
  logic                         out_update_r;
  logic                         out_uv_r;
  logic                         out_pdown_r;
  svs_pkg::svs_level_t          out_level_r;

  assign en = !out_valid_r || out_ch.ready;

  assign thr = (svs_pkg::THR_W'(cfg.code) + svs_pkg::THR_W'(svs_pkg::THRESHOLD_OFFSET))
               * svs_pkg::THR_W'(svs_pkg::THRESH_SCALE);
  assign meas_w       = svs_pkg::THR_W'(meas.volt);
  assign measuring    = meas.valid && meas.measure;
  assign deadline_new = meas.now + svs_pkg::TICK_W'(svs_pkg::SHUTDOWN_DELAY);

  always_comb begin
    voltage_nxt  = voltage_r;
    uv_flag_nxt  = uv_flag_r;
    deadline_nxt = deadline_r;
    update       = 1'b0;
    pdown        = 1'b0;
    if (measuring) begin
      update      = (meas.volt != voltage_r);
      voltage_nxt = meas.volt;
      if (cfg.shutdown_enable && (meas_w < thr)) begin
        uv_flag_nxt = 1'b1;
        update      = 1'b1;
        // Receive mode holds the deadline; transmit mode keeps pushing it out.
        if (!meas.tx) begin
          pdown = (meas.now > deadline_r);
        end else begin
          deadline_nxt = deadline_new;
        end
      end else begin
        if (uv_flag_r) begin
          update = 1'b1;
        end
        uv_flag_nxt  = 1'b0;
        deadline_nxt = deadline_new;
      end
    end
  end

  // Level follows the voltage as it stands after this item.
  assign volt_w = svs_pkg::THR_W'(voltage_nxt);

  always_comb begin
    if (volt_w < thr + svs_pkg::THR_W'(svs_pkg::MARGIN_RED)) begin
      level = svs_pkg::LVL_RED;
    end else if (volt_w < thr + svs_pkg::THR_W'(svs_pkg::MARGIN_ORANGE)) begin
      level = svs_pkg::LVL_ORANGE;
    end else if (volt_w < thr + svs_pkg::THR_W'(svs_pkg::MARGIN_YELLOW)) begin
      level = svs_pkg::LVL_YELLOW;
    end else begin
      level = svs_pkg::LVL_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voltage_r   <= '0;
      uv_flag_r   <= 1'b0;
      deadline_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      voltage_r   <= voltage_nxt;
      uv_flag_r   <= uv_flag_nxt;
      deadline_r  <= deadline_nxt;
      out_valid_r <= meas.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_measured_r <= measuring;
      out_voltage_r  <= voltage_nxt;
      out_update_r   <= update;
      out_uv_r       <= uv_flag_nxt;
      out_pdown_r    <= pdown;
      out_level_r    <= level;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.measured           = out_measured_r;
  assign out_ch.voltage            = out_voltage_r;
  assign out_ch.display_update     = out_update_r;
  assign out_ch.undervoltage       = out_uv_r;
  assign out_ch.power_down_request = out_pdown_r;
  assign out_ch.level              = out_level_r;

endmodule

[sv/supply_voltage_supervisor.sv]
// Supply voltage supervisor. Takes one beat per clock while not held and returns
// one result beat per input beat, in order; the result shows on out_ch having
// passed four registers (input register, scale multiply, reciprocal multiply
// for the divide by 2500, decision register). The four stages advance together
// and hold as one while a result waits on out_ch.ready, so the sustained rate
// is one beat per cycle whenever the result side takes every beat. Every
// SAMPLES+1-th beat measures and its own sample is not used. Configuration is
// written through the APB port at byte addresses 0 (calibration), 4 (threshold
// code) and 8 (shutdown enable); the user must write it only while no beat is
// in flight, as the block itself does not enforce this.
// Depends on svs_pkg, svs_in_if, svs_out_if, svs_cfg_regs, svs_scale, svs_decide.
module supply_voltage_supervisor (
  input  logic                         clk,
  input  logic                         rst_n,
  svs_in_if.sink                       in_ch,
  svs_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [svs_pkg::ADDR_W-1:0]   paddr,
  input  logic [svs_pkg::DATA_W-1:0]   pwdata,
  output logic [svs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  svs_pkg::svs_cfg_t   cfg;
  svs_pkg::svs_meas_t  meas;
  logic                en;

  svs_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  svs_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_ch (in_ch),
    .cfg   (cfg),
    .meas  (meas)
  );

  svs_decide u_decide (
    .clk    (clk),
    .rst_n  (rst_n),
    .meas   (meas),
    .cfg    (cfg),
    .out_ch (out_ch),
    .en     (en)
  );

  // A power-down request only comes from a measuring beat that found undervoltage.
  a_pdown_needs_uv: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.power_down_request |-> out_ch.measured && out_ch.undervoltage)
    else $error("power-down request without undervoltage measurement");

  a_update_on_measure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.display_update |-> out_ch.measured)
    else $error("display update on a beat that did not measure");

  // Below threshold is always inside the red margin.
  a_uv_is_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.measured && out_ch.undervoltage
      |-> out_ch.level == svs_pkg::LVL_RED)
    else $error("undervoltage reported outside the red level");

  a_uv_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.measured && !cfg.shutdown_enable |-> !out_ch.undervoltage)
    else $error("undervoltage flagged while detection is disabled");

endmodule

[tb/sv/svs_report_checker.sv]
`timescale 1ns / 100ps
// Report checker for the supply voltage supervisor: mirrors the averaging,
// scaling and undervoltage logic, expects one report per input beat, compares.
// Depends on svs_pkg, svs_in_if and svs_out_if.
module svs_report_checker
  import svs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  svs_in_if                 in_mon,
  svs_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatch_count,
  output int                reports_pending
);

  typedef struct packed {
    logic              measured;
    logic [VOLT_W-1:0] voltage;
    logic              display_update;
    logic              undervoltage;
    logic              power_down_request;
    svs_level_t        level;
  } svs_report_t;

  logic [CAL_W-1:0]  cal_q;
  logic [CODE_W-1:0] code_q;
  logic              shutdown_en_q;
  int unsigned       sum_q;
  int unsigned       count_q;
  logic [VOLT_W-1:0] volt_q;
  logic              uv_q;
  logic [TICK_W-1:0] deadline_q;
  svs_report_t       awaited_reports[$];

  function automatic int unsigned threshold_now();
    return (code_q + THRESHOLD_OFFSET) * THRESH_SCALE;
  endfunction

  function automatic svs_level_t margin_of(logic [VOLT_W-1:0] v);
    int unsigned thr;
    thr = threshold_now();
    if (v < thr + MARGIN_RED) return LVL_RED;
    if (v < thr + MARGIN_ORANGE) return LVL_ORANGE;
    if (v < thr + MARGIN_YELLOW) return LVL_YELLOW;
    return LVL_NORMAL;
  endfunction

  // Advances the mirrored supervisor by one beat and returns its report.
  function automatic svs_report_t supervise_beat(logic [SAMPLE_W-1:0] sample, logic tx,
                                                 logic [TICK_W-1:0] now);
    svs_report_t       r;
    int unsigned       avg;
    int unsigned       scaled;
    logic [VOLT_W-1:0] v;
    r = '0;
    if (count_q < SAMPLES) begin
      sum_q += sample;
      count_q++;
    end else begin
      // The measuring beat drops its own sample.
      avg = sum_q / SAMPLES;
      scaled = avg * (cal_q + CAL_BASE) / VOLT_DIV;
      v = scaled[VOLT_W-1:0];
      sum_q = 0;
      count_q = 0;
      r.measured = 1'b1;
      r.display_update = (v != volt_q);
      volt_q = v;
      if (shutdown_en_q && v < threshold_now()) begin
        uv_q = 1'b1;
        r.display_update = 1'b1;
        if (!tx) begin
          r.power_down_request = (now > deadline_q);
        end else begin
          deadline_q = now + SHUTDOWN_DELAY;
        end
      end else begin
        if (uv_q) begin
          r.display_update = 1'b1;
          uv_q = 1'b0;
        end
        deadline_q = now + SHUTDOWN_DELAY;
      end
    end
    r.voltage = volt_q;
    r.undervoltage = uv_q;
    r.level = margin_of(volt_q);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    svs_report_t want;
    if (!rst_n) begin
      cal_q = 8'd100;  // calibration trim out of reset
      code_q = '0;
      shutdown_en_q = 1'b0;
      sum_q = 0;
      count_q = 0;
      volt_q = '0;
      uv_q = 1'b0;
      deadline_q = '0;
      awaited_reports.delete();
      mismatch_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[ADDR_W-1:2])
          REG_CAL:      cal_q = pwdata[CAL_W-1:0];
          REG_THRESH:   code_q = pwdata[CODE_W-1:0];
          REG_SHUTDOWN: shutdown_en_q = pwdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        awaited_reports.push_back(supervise_beat(in_mon.adc_sample, in_mon.transmitting,
                                                 in_mon.now_ticks));
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: report beat with none expected, expected none, actual voltage %0d",
                   $time, out_mon.voltage);
        end else begin
          want = awaited_reports.pop_front();
          check_field("measured", want.measured, out_mon.measured);
          check_field("voltage", want.voltage, out_mon.voltage);
          check_field("display_update", want.display_update, out_mon.display_update);
          check_field("undervoltage", want.undervoltage, out_mon.undervoltage);
          check_field("power_down_request", want.power_down_request,
                      out_mon.power_down_request);
          check_field("level", want.level, out_mon.level);
        end
      end
    end
    reports_pending = awaited_reports.size();
  end

endmodule

[tb/sv/tb_supply_voltage_supervisor.sv]
`timescale 1ns / 100ps
// Testbench top for the supply voltage supervisor: clock, reset, sample and
// register stimulus, idling and the verdict. Depends on svs_pkg, svs_in_if,
// svs_out_if, supply_voltage_supervisor and svs_report_checker.
module tb_supply_voltage_supervisor;
  import svs_pkg::*;

  localparam int WINDOWS       = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DIRECTED      = 25;
  localparam int SAMPLE_MAX    = (2 ** SAMPLE_W) - 1;
  localparam logic [1:0] UNMAPPED_REG = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                mismatch_count;
  int                reports_pending;
  int                send_idle_pct = 14;
  int                recv_idle_pct = 65;
  int                quiet_cycles = 0;
  logic [CAL_W-1:0]  cur_cal = 8'd100;
  logic [CODE_W-1:0] cur_code = '0;
  logic [TICK_W-1:0] last_meas_now;
  int                last_avg = 0;
  logic [SAMPLE_W-1:0] corner_samples[4] = '{12'h000, 12'hFFF, 12'hAAA, 12'h555};
  logic [TICK_W-1:0]   corner_ticks[4] = '{32'h0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};

  svs_in_if  in_ch();
  svs_out_if out_ch();

  supply_voltage_supervisor DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  svs_report_checker report_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [SAMPLE_W-1:0] sample, input logic tx,
                           input logic [TICK_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.adc_sample <= sample;
    in_ch.transmitting <= tx;
    in_ch.now_ticks <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Holds the sender until every report is back, then lets the pipeline settle.
  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Upper bits of every write are random; the block keeps only the field.
  task automatic configure(input logic [CAL_W-1:0] cal, input logic [CODE_W-1:0] code,
                           input logic shutdown);
    logic [DATA_W-1:0] word;
    drain_reports();
    word = $urandom;
    word[CAL_W-1:0] = cal;
    reg_write(REG_CAL, word);
    word = $urandom;
    word[CODE_W-1:0] = code;
    reg_write(REG_THRESH, word);
    word = $urandom;
    word[0] = shutdown;
    reg_write(REG_SHUTDOWN, word);
    if ($urandom_range(0, 3) == 0) reg_write(UNMAPPED_REG, $urandom);
    cur_cal = cal;
    cur_code = code;
  endtask

  task automatic configure_random();
    logic [CAL_W-1:0]  cal;
    logic [CODE_W-1:0] code;
    case ($urandom_range(0, 3))
      0:       cal = '0;
      1:       cal = '1;
      2:       cal = 8'd100;
      default: cal = CAL_W'($urandom);
    endcase
    case ($urandom_range(0, 2))
      0:       code = '0;
      1:       code = '1;
      default: code = CODE_W'($urandom);
    endcase
    configure(cal, code, $urandom_range(0, 9) < 8);
  endtask

  // One averaging window: the rest of the accumulating beats, then the
  // measuring beat. Most windows aim the average at a chosen voltage band.
  task automatic run_window(input int first);
    int kind;
    int avg;
    int jitter;
    int thr;
    int target;
    int s;
    int k;
    logic [TICK_W-1:0] now;
    kind = $urandom_range(0, 9);
    thr = (cur_code + THRESHOLD_OFFSET) * THRESH_SCALE;
    k = cur_cal + CAL_BASE;
    avg = 0;
    case (kind)
      0: avg = 0;
      1: avg = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      2: avg = last_avg;
      default: begin
        case ($urandom_range(0, 7))
          0, 1, 2: target = $urandom_range(0, thr - 1);
          3:       target = $urandom_range(thr, thr + MARGIN_RED - 1);
          4:       target = $urandom_range(thr + MARGIN_RED, thr + MARGIN_ORANGE - 1);
          5:       target = $urandom_range(thr + MARGIN_ORANGE, thr + MARGIN_YELLOW - 1);
          6:       target = $urandom_range(thr + MARGIN_YELLOW, thr + 400);
          default: target = thr - 1 + $urandom_range(0, 1);
        endcase
        // Rounded-up inverse of the scale, so a flat window lands on target.
        avg = (target * VOLT_DIV + k - 1) / k;
        if (avg > SAMPLE_MAX) avg = SAMPLE_MAX;
      end
    endcase
    jitter = (kind <= 2 || $urandom_range(0, 1)) ? 0 : 4;
    for (int i = first; i < SAMPLES; i++) begin
      if (kind == 0) begin
        s = $urandom_range(0, SAMPLE_MAX);
      end else begin
        s = avg + $urandom_range(0, 2 * jitter) - jitter;
        if (s < 0) s = 0;
        if (s > SAMPLE_MAX) s = SAMPLE_MAX;
      end
      send_beat(SAMPLE_W'(s), 1'($urandom_range(0, 1)), $urandom);
    end
    last_avg = avg;
    // Measurement times straddle the deadline set by the previous measurement.
    case ($urandom_range(0, 4))
      0:       now = last_meas_now + SHUTDOWN_DELAY - 1;
      1:       now = last_meas_now + SHUTDOWN_DELAY;
      2:       now = last_meas_now + SHUTDOWN_DELAY + 1;
      3:       now = last_meas_now + $urandom_range(0, 2 * SHUTDOWN_DELAY);
      default: now = $urandom;
    endcase
    send_beat(SAMPLE_W'($urandom), 1'($urandom_range(0, 1)), now);
    last_meas_now = now;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.adc_sample = '0;
    in_ch.transmitting = 1'b0;
    in_ch.now_ticks = '0;
    // Start close to the top of the tick range so early deadlines wrap.
    last_meas_now = 32'hFFFF_E000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    configure(8'd100, '0, 1'b1);
    for (int i = 0; i < DIRECTED; i++)
      send_beat(corner_samples[i % 4], i[0], corner_ticks[(i / 4) % 4]);
    run_window(DIRECTED);

    for (int w = 1; w < WINDOWS; w++) begin
      if (w == WINDOWS / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 14;
      end else if (w == 2 * WINDOWS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (w == 1)
        configure('1, '1, 1'b1);
      else if (w == 2)
        configure('0, '0, 1'b0);
      else
        configure_random();
      run_window(0);
    end

    drain_reports();
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/svs_pkg.sv
sv/svs_in_if.sv
sv/svs_out_if.sv
sv/svs_cfg_regs.sv
sv/svs_scale.sv
sv/svs_decide.sv
sv/supply_voltage_supervisor.sv
tb/sv/svs_report_checker.sv
tb/sv/tb_supply_voltage_supervisor.sv
